FILE: hw/rtl/rxap_pkg.sv
`timescale 1ns / 1ps

package rxap_pkg;

	localparam int unsigned WORD_W = 32;
	localparam logic [WORD_W-1:0] MIX_CONST = 32'h1234_567F;
	localparam logic [WORD_W-1:0] ALL_ONES = '1;
	localparam int unsigned RETRY_LIMIT = 256;
	localparam int unsigned TRIES_W = $clog2(RETRY_LIMIT);
	localparam logic [TRIES_W-1:0] TRIES_LAST = TRIES_W'(RETRY_LIMIT - 1);

	localparam logic [1:0] CMD_RAW = 2'd0;
	localparam logic [1:0] CMD_BOUNDED = 2'd1;
	localparam logic [1:0] CMD_SEED = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CAPDIV,
		S_DRAW,
		S_MODDIV,
		S_OUT
	} state_t;

	typedef enum logic [1:0] {
		RES_ZERO,
		RES_DRAW,
		RES_MASK,
		RES_REM
	} res_sel_t;

	typedef struct packed {
		logic     load_seed;
		logic     step;
		logic     res_load;
		res_sel_t res_sel;
		logic     bound_load;
		logic     div_start;
		logic     div_sel_ones;
		logic     cap_load;
		logic     out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic bound_lt2;
		logic bound_pow2;
		logic draw_reject;
		logic div_done;
	} dp_sts_t;

endpackage

FILE: hw/rtl/rxap_div.sv
`timescale 1ns / 1ps

module rxap_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [rxap_pkg::WORD_W-1:0] dividend,
	input  logic [rxap_pkg::WORD_W-1:0] divisor,
	output logic                       done,
	output logic [rxap_pkg::WORD_W-1:0] remainder
);
	import rxap_pkg::*;

	localparam int unsigned CNT_W = $clog2(WORD_W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORD_W - 1);

	logic [WORD_W-1:0] num_q;
	logic [WORD_W-1:0] rem_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [WORD_W:0]   trial;
	logic [WORD_W-1:0] rem_nxt;

	always_comb begin
		trial = {rem_q, num_q[WORD_W-1]};
		if (trial >= {1'b0, divisor}) begin
			rem_nxt = WORD_W'(trial - {1'b0, divisor});
		end else begin
			rem_nxt = trial[WORD_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q <= '0;
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_LAST) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[WORD_W-2:0], 1'b0};
			rem_q <= rem_nxt;
		end
	end

	assign done = done_q;
	assign remainder = rem_q;

endmodule

FILE: hw/rtl/rxap_dp.sv
`timescale 1ns / 1ps

module rxap_dp (
	input  logic                       clk,
	input  logic                       arst_n,
	input  rxap_pkg::dp_cmd_t          cmd,
	output rxap_pkg::dp_sts_t          sts,
	input  logic [rxap_pkg::WORD_W-1:0] bound,
	input  logic [rxap_pkg::WORD_W-1:0] seed_first,
	input  logic [rxap_pkg::WORD_W-1:0] seed_second,
	output logic [rxap_pkg::WORD_W-1:0] value
);
	import rxap_pkg::*;

	logic [WORD_W-1:0] word_first_q;
	logic [WORD_W-1:0] word_second_q;
	logic [WORD_W-1:0] bound_q;
	logic [WORD_W-1:0] cap_q;
	logic [WORD_W-1:0] res_q;
	logic [WORD_W-1:0] value_q;
	logic [WORD_W-1:0] mixed;
	logic [WORD_W-1:0] next_first;
	logic [WORD_W-1:0] next_second;
	logic [WORD_W-1:0] bound_m1;
	logic [WORD_W-1:0] div_dividend;
	logic [WORD_W-1:0] div_rem;
	logic              div_done;
	logic [WORD_W-1:0] res_nxt;

	always_comb begin
		mixed = word_second_q ^ MIX_CONST;
		next_first = word_first_q + {mixed[6:0], mixed[WORD_W-1:7]};
		next_second = {word_first_q[2:0], word_first_q[WORD_W-1:3]};
		bound_m1 = bound - 1'b1;
		div_dividend = cmd.div_sel_ones ? ALL_ONES : next_second;
		case (cmd.res_sel)
			RES_DRAW: res_nxt = next_second;
			RES_MASK: res_nxt = next_second & bound_m1;
			RES_REM:  res_nxt = div_rem;
			default:  res_nxt = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_first_q <= '0;
			word_second_q <= '0;
		end else if (cmd.load_seed) begin
			word_first_q <= seed_first;
			word_second_q <= seed_second;
		end else if (cmd.step) begin
			word_first_q <= next_first;
			word_second_q <= next_second;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.bound_load) begin
			bound_q <= bound;
		end
		if (cmd.cap_load) begin
			cap_q <= ~div_rem - 1'b1;
		end
		if (cmd.res_load) begin
			res_q <= res_nxt;
		end
		if (cmd.out_load) begin
			value_q <= res_q;
		end
	end

	rxap_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (div_dividend),
		.divisor   (bound_q),
		.done      (div_done),
		.remainder (div_rem)
	);

	assign sts.bound_lt2 = (bound[WORD_W-1:1] == '0);
	assign sts.bound_pow2 = ((bound & bound_m1) == '0);
	assign sts.draw_reject = (next_second > cap_q);
	assign sts.div_done = div_done;
	assign value = value_q;

endmodule

FILE: hw/rtl/rxap_ctrl.sv
`timescale 1ns / 1ps

module rxap_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        command,
	output logic              out_valid,
	input  logic              out_stall,
	output rxap_pkg::dp_cmd_t cmd,
	input  rxap_pkg::dp_sts_t sts
);
	import rxap_pkg::*;

	state_t           state_q;
	state_t           state_nxt;
	logic [TRIES_W-1:0] tries_q;
	logic             out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			tries_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.cap_load) begin
				tries_q <= '0;
			end else if (state_q == S_DRAW) begin
				tries_q <= tries_q + 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd = '0;
		cmd.res_sel = RES_ZERO;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_nxt = S_OUT;
					cmd.res_load = 1'b1;
					case (command)
						CMD_RAW: begin
							cmd.step = 1'b1;
							cmd.res_sel = RES_DRAW;
						end
						CMD_BOUNDED: begin
							if (sts.bound_lt2) begin
								cmd.res_sel = RES_ZERO;
							end else if (sts.bound_pow2) begin
								cmd.step = 1'b1;
								cmd.res_sel = RES_MASK;
							end else begin
								cmd.res_load = 1'b0;
								cmd.bound_load = 1'b1;
								cmd.div_start = 1'b1;
								cmd.div_sel_ones = 1'b1;
								state_nxt = S_CAPDIV;
							end
						end
						CMD_SEED: begin
							cmd.load_seed = 1'b1;
						end
						default: begin
							cmd.res_sel = RES_ZERO;
						end
					endcase
				end
			end
			S_CAPDIV: begin
				if (sts.div_done) begin
					cmd.cap_load = 1'b1;
					state_nxt = S_DRAW;
				end
			end
			S_DRAW: begin
				cmd.step = 1'b1;
				if (!sts.draw_reject || tries_q == TRIES_LAST) begin
					cmd.div_start = 1'b1;
					state_nxt = S_MODDIV;
				end
			end
			S_MODDIV: begin
				if (sts.div_done) begin
					cmd.res_load = 1'b1;
					cmd.res_sel = RES_REM;
					state_nxt = S_OUT;
				end
			end
			S_OUT: begin
				if (!out_valid_q || !out_stall) begin
					cmd.out_load = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	assign in_stall = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

endmodule

FILE: hw/rtl/rotate_xor_add_prng_bounded.sv
`timescale 1ns / 1ps

// Rotate-xor-add random generator with raw, bounded and reseed commands.
// The input channel (in_valid, in_stall) carries command, bound and the two
// seed words; each transfer yields exactly one transfer of value on the
// output channel (out_valid, out_stall), in order.
// A raw draw, a reseed, a bound under two or a power-of-two bound goes from
// the input transfer through S_OUT to output valid, and unless the output
// is held the next item is taken in that same cycle; input stays stalled
// while an item is in progress. Any other bound runs the shared bit-serial
// divider twice, once to find the rejection cap and once for the final
// remainder, with the draws in between; there are at most 256 draws,
// usually one.
// The result sits in an output register, so the block goes back to taking
// input while a finished value waits for the receiver. When the receiver
// stalls with a value still held, the next result waits in the controller
// and input stays stalled until the held value is taken.
// Reset clears both state words to zero and leaves the output empty.
module rotate_xor_add_prng_bounded (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  command,
	input  logic [31:0] bound,
	input  logic [31:0] seed_first,
	input  logic [31:0] seed_second,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] value
);
	import rxap_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	rxap_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.command   (command),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	rxap_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.bound       (bound),
		.seed_first  (seed_first),
		.seed_second (seed_second),
		.value       (value)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while an item is still in progress");

	a_out_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !out_valid || !out_stall)
		else $error("output register overwritten before its transfer");

	a_div_not_instant: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> !sts.div_done)
		else $error("divider reported done right after start");

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import rxap_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int unsigned QUIET_LIMIT = 4000;
	localparam int unsigned DRAIN_CYCLES = 400;
	localparam int unsigned RANDOM_ITEMS = 1900;

	class draw_scoreboard;
		logic [WORD_W-1:0] word_first;
		logic [WORD_W-1:0] word_second;
		logic [WORD_W-1:0] expected_values[$];
		int unsigned mismatches;

		function new();
			word_first = '0;
			word_second = '0;
			mismatches = 0;
		endfunction

		function logic [WORD_W-1:0] next_word();
			logic [WORD_W-1:0] old_first;
			logic [WORD_W-1:0] mixed;
			old_first = word_first;
			mixed = word_second ^ MIX_CONST;
			word_first = word_first + {mixed[6:0], mixed[31:7]};
			word_second = {old_first[2:0], old_first[31:3]};
			return word_second;
		endfunction

		function void note_input(logic [1:0] cmd, logic [WORD_W-1:0] limit,
				logic [WORD_W-1:0] first, logic [WORD_W-1:0] second);
			logic [WORD_W-1:0] result;
			logic [WORD_W-1:0] cap;
			logic [WORD_W-1:0] sample;
			int unsigned tries;
			result = '0;
			case (cmd)
				CMD_RAW: begin
					result = next_word();
				end
				CMD_BOUNDED: begin
					if (limit < 32'd2) begin
						result = '0;
					end else if ((limit & (limit - 32'd1)) == '0) begin
						result = next_word() & (limit - 32'd1);
					end else begin
						cap = ALL_ONES - (ALL_ONES % limit) - 32'd1;
						sample = next_word();
						tries = 1;
						while (sample > cap && tries < RETRY_LIMIT) begin
							sample = next_word();
							tries++;
						end
						result = sample % limit;
					end
				end
				CMD_SEED: begin
					word_first = first;
					word_second = second;
				end
				default: begin
					result = '0;
				end
			endcase
			expected_values.push_back(result);
		endfunction

		task report(string msg);
			$display("mismatch at %0t ns: %s", $realtime, msg);
			mismatches++;
		endtask

		task check_result(logic [WORD_W-1:0] got);
			logic [WORD_W-1:0] want;
			if (expected_values.size() == 0) begin
				report($sformatf("value %08h with no transfer pending", got));
			end else begin
				want = expected_values.pop_front();
				if (got !== want)
					report($sformatf("value %08h, expected %08h", got, want));
			end
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  command;
	logic [31:0] bound;
	logic [31:0] seed_first;
	logic [31:0] seed_second;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] value;

	draw_scoreboard scoreboard;
	int unsigned idle_pct;
	int unsigned stall_pct;
	int unsigned quiet_cycles;

	rotate_xor_add_prng_bounded i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.command(command),
		.bound(bound),
		.seed_first(seed_first),
		.seed_second(seed_second),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.value(value)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				scoreboard.check_result(value);
			if (in_valid && !in_stall)
				scoreboard.note_input(command, bound, seed_first, seed_second);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("testbench failed");
				$finish;
			end
		end
	end

	task automatic send_item(input logic [1:0] cmd, input logic [31:0] limit,
			input logic [31:0] first, input logic [31:0] second);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		bound <= limit;
		seed_first <= first;
		seed_second <= second;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic send_random_item();
		logic [1:0]  cmd;
		logic [31:0] limit;
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 30)
			cmd = CMD_RAW;
		else if (pick < 80)
			cmd = CMD_BOUNDED;
		else if (pick < 92)
			cmd = CMD_SEED;
		else
			cmd = CMD_UNUSED;
		case ($urandom_range(9))
			0: limit = $urandom_range(1);
			1: limit = 32'd1 << $urandom_range(31);
			2: limit = $urandom_range(1000, 3);
			3: limit = 32'h8000_0000 + $urandom_range(32'hFFFF, 1);
			4: limit = ALL_ONES - $urandom_range(3);
			default: limit = $urandom;
		endcase
		send_item(cmd, limit, $urandom, $urandom);
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		command = CMD_RAW;
		bound = '0;
		seed_first = '0;
		seed_second = '0;
		out_stall = 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		quiet_cycles = 0;
		scoreboard = new();

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The zero state after reset, the bounds that leave the state alone, the
		// extremes of the bound, and a seed that makes the state a fixed point.
		send_item(CMD_RAW, '0, '0, '0);
		send_item(CMD_RAW, '0, '0, '0);
		send_item(CMD_BOUNDED, 32'd0, ALL_ONES, ALL_ONES);
		send_item(CMD_BOUNDED, 32'd1, ALL_ONES, ALL_ONES);
		send_item(CMD_UNUSED, ALL_ONES, ALL_ONES, ALL_ONES);
		send_item(CMD_SEED, ALL_ONES, ALL_ONES, ALL_ONES);
		send_item(CMD_RAW, '0, '0, '0);
		send_item(CMD_BOUNDED, ALL_ONES, '0, '0);
		send_item(CMD_BOUNDED, 32'h8000_0000, '0, '0);
		send_item(CMD_BOUNDED, 32'h8000_0001, '0, '0);
		send_item(CMD_BOUNDED, 32'd2, '0, '0);
		send_item(CMD_BOUNDED, 32'd3, '0, '0);
		send_item(CMD_SEED, '0, '0, '0);
		send_item(CMD_RAW, '0, '0, '0);
		send_item(CMD_SEED, '0, {MIX_CONST[28:0], MIX_CONST[31:29]}, MIX_CONST);
		send_item(CMD_RAW, '0, '0, '0);
		send_item(CMD_BOUNDED, 32'h8000_0001, '0, '0);
		send_item(CMD_RAW, '0, '0, '0);
		send_item(CMD_BOUNDED, 32'hFFFF_FFFE, '0, '0);
		send_item(CMD_BOUNDED, 32'd7, '0, '0);
		send_item(CMD_SEED, '0, $urandom, $urandom);
		send_item(CMD_BOUNDED, 32'd1, ALL_ONES, ALL_ONES);
		send_item(CMD_UNUSED, '0, '0, '0);

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 55; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 55; end
				default: begin idle_pct = 10; stall_pct = 10; end
			endcase
			for (int n = 0; n < RANDOM_ITEMS / 4; n++)
				send_random_item();
		end
		in_valid <= 1'b0;

		while (scoreboard.expected_values.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (scoreboard.expected_values.size() != 0)
			scoreboard.report("expected values left over at the end");

		if (scoreboard.mismatches == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule
